>>> rtl/amgs_pkg.sv
// shared types, operation codes and sizes for the graph store
`default_nettype none
package amgs_pkg;
	localparam int unsigned MAX_VERTICES_DEF = 16;
	localparam int unsigned ID_W = 32;

	localparam logic [2:0] M_ADD_VERTEX = 3'd0;
	localparam logic [2:0] M_ADD_EDGE   = 3'd1;
	localparam logic [2:0] M_ADD_WEIGHT = 3'd2;
	localparam logic [2:0] M_REM_VERTEX = 3'd3;
	localparam logic [2:0] M_REM_EDGE   = 3'd4;
	localparam logic [2:0] M_READ_EDGE  = 3'd5;

	localparam logic KIND_UNDIRECTED = 1'b0;
	localparam logic KIND_DIRECTED   = 1'b1;

	localparam logic [1:0] WR_ROW = 2'd0;
	localparam logic [1:0] WR_XY  = 2'd1;
	localparam logic [1:0] WR_YX  = 2'd2;
	localparam logic [1:0] WR_COL = 2'd3;

	typedef struct packed {
		logic [2:0]             mode;
		logic signed [ID_W-1:0] vertex_id;
		logic signed [ID_W-1:0] from_id;
		logic signed [ID_W-1:0] to_id;
		logic signed [ID_W-1:0] weight;
	} cmd_t;

	typedef struct packed {
		logic                   ok;
		logic signed [ID_W-1:0] edge_value;
		logic [4:0]             vertex_count;
	} res_t;

	typedef struct packed {
		logic       load;
		logic       scan_rd;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       rd_en;
		logic       commit;
		logic       finish;
	} ctl_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] mode;
		logic       kind;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/amgs_datapath.sv
// datapath: vertex ring, adjacency memory, lookup compare and result register
`default_nettype none
module amgs_datapath #(
	parameter int unsigned MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF,
	parameter int unsigned SW = $clog2(MAX_VERTICES),
	parameter int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire                    cfg_wdata,
	input  amgs_pkg::cmd_t         cmd_in,
	input  amgs_pkg::ctl_t         ctl,
	input  wire [SW-1:0]           idx,
	output amgs_pkg::sts_t         sts,
	output logic [CW-1:0]          count,
	output amgs_pkg::res_t         result,
	output logic                   done
);
	localparam int unsigned AW = 2 * SW;

	logic [amgs_pkg::ID_W-1:0] vt_mem [0:MAX_VERTICES-1];
	logic [amgs_pkg::ID_W-1:0] adj_mem [0:(1 << AW)-1];

	amgs_pkg::cmd_t            cmd_q;
	logic                      kind_q;
	logic [SW-1:0]             front_q, rear_q, x_q, y_q, slot_s1;
	logic [CW-1:0]             count_q;
	logic                      fx_q, fy_q, vld_s1;
	logic [amgs_pkg::ID_W-1:0] vt_rd_s1, adj_rd_q;
	amgs_pkg::res_t            res_q;
	logic                      done_q;
	logic                      ok_q;

	logic [SW:0]               ring_sum;
	logic [SW-1:0]             ring, rear_inc, rear_dec, front_inc, wr_row, wr_col;
	logic [amgs_pkg::ID_W-1:0] key_a, wr_data, edge_data;
	logic                      ends_differ, ok;

	assign ring_sum  = {1'b0, front_q} + {1'b0, idx};
	assign ring      = (ring_sum >= (SW+1)'(MAX_VERTICES)) ?
		SW'(ring_sum - (SW+1)'(MAX_VERTICES)) : ring_sum[SW-1:0];
	assign rear_inc  = (rear_q == SW'(MAX_VERTICES - 1)) ? '0 : rear_q + SW'(1);
	assign rear_dec  = (rear_q == '0) ? SW'(MAX_VERTICES - 1) : rear_q - SW'(1);
	assign front_inc = (front_q == SW'(MAX_VERTICES - 1)) ? '0 : front_q + SW'(1);

	assign key_a = (cmd_q.mode == amgs_pkg::M_ADD_VERTEX || cmd_q.mode == amgs_pkg::M_REM_VERTEX)
		? cmd_q.vertex_id : cmd_q.from_id;
	assign ends_differ = (cmd_q.from_id != cmd_q.to_id);

	always_comb begin
		case (cmd_q.mode)
			amgs_pkg::M_ADD_VERTEX: ok = (count_q < CW'(MAX_VERTICES)) && !fx_q;
			amgs_pkg::M_ADD_EDGE:   ok = (kind_q == amgs_pkg::KIND_UNDIRECTED) && ends_differ
				&& fx_q && fy_q;
			amgs_pkg::M_ADD_WEIGHT: ok = (kind_q == amgs_pkg::KIND_DIRECTED) && ends_differ
				&& fx_q && fy_q;
			amgs_pkg::M_REM_VERTEX: ok = fx_q && (x_q == rear_q || x_q == front_q);
			amgs_pkg::M_REM_EDGE:   ok = fx_q && fy_q;
			amgs_pkg::M_READ_EDGE:  ok = fx_q && fy_q;
			default:                ok = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd_q.mode)
			amgs_pkg::M_ADD_WEIGHT: edge_data = cmd_q.weight;
			amgs_pkg::M_REM_EDGE:   edge_data = '0;
			default:                edge_data = amgs_pkg::ID_W'(1);
		endcase
	end

	always_comb begin
		case (ctl.wr_sel)
			amgs_pkg::WR_ROW: begin
				wr_row  = rear_inc;
				wr_col  = idx;
				wr_data = (idx == rear_inc) ? amgs_pkg::ID_W'(1) : '0;
			end
			amgs_pkg::WR_XY: begin
				wr_row  = x_q;
				wr_col  = y_q;
				wr_data = edge_data;
			end
			amgs_pkg::WR_YX: begin
				wr_row  = y_q;
				wr_col  = x_q;
				wr_data = edge_data;
			end
			default: begin
				wr_row  = ring;
				wr_col  = x_q;
				wr_data = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			cmd_q <= cmd_in;
		if (ctl.scan_rd)
			vt_rd_s1 <= vt_mem[ring];
		slot_s1 <= ring;
		// verdict as seen before the commit moves the ring
		ok_q <= ok;
		if (ctl.commit && cmd_q.mode == amgs_pkg::M_ADD_VERTEX)
			vt_mem[rear_inc] <= cmd_q.vertex_id;
		if (ctl.wr_en)
			adj_mem[{wr_row, wr_col}] <= wr_data;
		if (ctl.rd_en)
			adj_rd_q <= adj_mem[{x_q, y_q}];
		if (vld_s1 && vt_rd_s1 == key_a)
			x_q <= slot_s1;
		if (vld_s1 && vt_rd_s1 == cmd_q.to_id)
			y_q <= slot_s1;
		if (ctl.finish) begin
			res_q.ok           <= ok_q;
			res_q.edge_value   <= (cmd_q.mode == amgs_pkg::M_READ_EDGE && ok_q) ? adj_rd_q : '0;
			res_q.vertex_count <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= 1'b0;
			front_q <= '0;
			rear_q  <= SW'(MAX_VERTICES - 1);
			count_q <= '0;
			fx_q    <= 1'b0;
			fy_q    <= 1'b0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we)
				kind_q <= cfg_wdata;
			vld_s1 <= ctl.scan_rd;
			done_q <= ctl.finish;
			if (ctl.load) begin
				fx_q <= 1'b0;
				fy_q <= 1'b0;
			end else if (vld_s1) begin
				if (vt_rd_s1 == key_a)
					fx_q <= 1'b1;
				if (vt_rd_s1 == cmd_q.to_id)
					fy_q <= 1'b1;
			end
			if (ctl.commit) begin
				if (cmd_q.mode == amgs_pkg::M_ADD_VERTEX) begin
					rear_q  <= rear_inc;
					count_q <= count_q + CW'(1);
				end else if (cmd_q.mode == amgs_pkg::M_REM_VERTEX) begin
					if (x_q == rear_q)
						rear_q <= rear_dec;
					else
						front_q <= front_inc;
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	assign sts.ok   = ok;
	assign sts.mode = cmd_q.mode;
	assign sts.kind = kind_q;
	assign count    = count_q;
	assign result   = res_q;
	assign done     = done_q;
endmodule
`default_nettype wire

>>> rtl/amgs_ctrl.sv
// controller: sequences lookup scan, matrix writes and result transfer
`default_nettype none
module amgs_ctrl #(
	parameter int unsigned MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF,
	parameter int unsigned SW = $clog2(MAX_VERTICES),
	parameter int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  amgs_pkg::sts_t         sts,
	input  wire [CW-1:0]           count,
	output amgs_pkg::ctl_t         ctl,
	output logic [SW-1:0]          idx,
	output logic                   busy
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_FLUSH = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]    st_q, st_d;
	logic [CW-1:0] j_q, j_d;

	assign idx  = j_q[SW-1:0];
	assign busy = (st_q != S_IDLE);

	always_comb begin
		st_d = st_q;
		j_d  = j_q;
		ctl  = '0;
		case (st_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					j_d      = '0;
					st_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (j_q < count) begin
					ctl.scan_rd = 1'b1;
					j_d         = j_q + CW'(1);
				end else begin
					st_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				j_d  = '0;
				st_d = S_EXEC;
			end
			S_EXEC: begin
				if (!sts.ok) begin
					st_d = S_DONE;
				end else begin
					case (sts.mode)
						amgs_pkg::M_ADD_VERTEX: begin
							ctl.wr_en  = 1'b1;
							ctl.wr_sel = amgs_pkg::WR_ROW;
							if (j_q == CW'(MAX_VERTICES - 1)) begin
								ctl.commit = 1'b1;
								st_d       = S_DONE;
							end else begin
								j_d = j_q + CW'(1);
							end
						end
						amgs_pkg::M_ADD_EDGE, amgs_pkg::M_REM_EDGE: begin
							ctl.wr_en = 1'b1;
							if (j_q == '0) begin
								ctl.wr_sel = amgs_pkg::WR_XY;
								if (sts.kind == amgs_pkg::KIND_UNDIRECTED)
									j_d = CW'(1);
								else
									st_d = S_DONE;
							end else begin
								ctl.wr_sel = amgs_pkg::WR_YX;
								st_d       = S_DONE;
							end
						end
						amgs_pkg::M_ADD_WEIGHT: begin
							ctl.wr_en  = 1'b1;
							ctl.wr_sel = amgs_pkg::WR_XY;
							st_d       = S_DONE;
						end
						amgs_pkg::M_REM_VERTEX: begin
							if (j_q < count) begin
								ctl.wr_en  = 1'b1;
								ctl.wr_sel = amgs_pkg::WR_COL;
								j_d        = j_q + CW'(1);
							end else begin
								ctl.commit = 1'b1;
								st_d       = S_DONE;
							end
						end
						amgs_pkg::M_READ_EDGE: begin
							ctl.rd_en = 1'b1;
							st_d      = S_DONE;
						end
						default: st_d = S_DONE;
					endcase
				end
			end
			S_DONE: begin
				ctl.finish = 1'b1;
				st_d       = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			j_q  <= '0;
		end else begin
			st_q <= st_d;
			j_q  <= j_d;
		end
	end

	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE && start) |=> (st_q == S_SCAN))
		else $error("transfer in did not begin lookup");
	a_commit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> sts.ok)
		else $error("commit on refused operation");
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (st_q == S_EXEC && sts.ok))
		else $error("matrix write outside accepted operation");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_VERTICES))
		else $error("vertex count above capacity");
endmodule
`default_nettype wire

>>> rtl/adjacency_matrix_graph_store_unit.sv
// top level of the adjacency matrix graph store
// throughput: one operation at a time, set by the lookup scan over held vertices
// and the entry-by-entry row or column clear through the single matrix write port
// reset: empty ring, undirected kind; memory contents stay undefined until written
`default_nettype none
module adjacency_matrix_graph_store_unit #(
	parameter int unsigned MAX_VERTICES = amgs_pkg::MAX_VERTICES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_we,
	input  wire            cfg_wdata,
	input  wire            start,
	input  amgs_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done,
	output amgs_pkg::res_t result
);
	localparam int unsigned SW = $clog2(MAX_VERTICES);
	localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

	amgs_pkg::ctl_t ctl;
	amgs_pkg::sts_t sts;
	logic [SW-1:0]  idx;
	logic [CW-1:0]  count;

	amgs_ctrl #(.MAX_VERTICES(MAX_VERTICES), .SW(SW), .CW(CW)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.count  (count),
		.ctl    (ctl),
		.idx    (idx),
		.busy   (busy)
	);

	amgs_datapath #(.MAX_VERTICES(MAX_VERTICES), .SW(SW), .CW(CW)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_in    (cmd),
		.ctl       (ctl),
		.idx       (idx),
		.sts       (sts),
		.count     (count),
		.result    (result),
		.done      (done)
	);
endmodule
`default_nettype wire

>>> test/adjacency_matrix_graph_store_unit_test.sv
// testbench for the adjacency matrix graph store against a behavioral model
`default_nettype none
module adjacency_matrix_graph_store_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NV = amgs_pkg::MAX_VERTICES_DEF;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic start = 1'b0;
	amgs_pkg::cmd_t cmd = '0;
	logic busy;
	logic done;
	amgs_pkg::res_t result;

	adjacency_matrix_graph_store_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .cmd(cmd), .busy(busy), .done(done), .result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// graph model state
	logic        kind_m;
	logic [31:0] ids_m [NV];
	logic [31:0] adj_m [NV][NV];
	int unsigned front_m, rear_m, count_m;

	amgs_pkg::res_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int transfers = 0;
	int results_seen = 0;
	bit calm = 1'b0;

	function automatic bit locate(logic [31:0] id, output int unsigned slot);
		slot = 0;
		for (int unsigned j = 0; j < count_m; j++) begin
			if (ids_m[(front_m + j) % NV] == id) begin
				slot = (front_m + j) % NV;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic amgs_pkg::res_t apply_operation(amgs_pkg::cmd_t c);
		amgs_pkg::res_t r;
		int unsigned x, y;
		bit fx, fy;
		logic [31:0] vid;
		r = '0;
		vid = c.vertex_id;
		fx = locate(c.from_id, x);
		fy = locate(c.to_id, y);
		case (c.mode)
			amgs_pkg::M_ADD_VERTEX: begin
				if (count_m < NV && !locate(vid, x)) begin
					count_m++;
					rear_m = (rear_m + 1) % NV;
					for (int j = 0; j < NV; j++) adj_m[rear_m][j] = '0;
					adj_m[rear_m][rear_m] = 32'd1;
					ids_m[rear_m] = vid;
					r.ok = 1'b1;
				end
			end
			amgs_pkg::M_ADD_EDGE: begin
				if (kind_m == amgs_pkg::KIND_UNDIRECTED && c.from_id != c.to_id && fx && fy) begin
					adj_m[x][y] = 32'd1;
					adj_m[y][x] = 32'd1;
					r.ok = 1'b1;
				end
			end
			amgs_pkg::M_ADD_WEIGHT: begin
				if (kind_m == amgs_pkg::KIND_DIRECTED && c.from_id != c.to_id && fx && fy) begin
					adj_m[x][y] = c.weight;
					r.ok = 1'b1;
				end
			end
			amgs_pkg::M_REM_VERTEX: begin
				if (locate(vid, y) && (ids_m[rear_m] == vid || ids_m[front_m] == vid)) begin
					for (int unsigned j = 0; j < count_m; j++) adj_m[(front_m + j) % NV][y] = '0;
					if (ids_m[rear_m] == vid) rear_m = (rear_m + NV - 1) % NV;
					else front_m = (front_m + 1) % NV;
					count_m--;
					r.ok = 1'b1;
				end
			end
			amgs_pkg::M_REM_EDGE: begin
				if (fx && fy) begin
					adj_m[x][y] = '0;
					if (kind_m == amgs_pkg::KIND_UNDIRECTED) adj_m[y][x] = '0;
					r.ok = 1'b1;
				end
			end
			amgs_pkg::M_READ_EDGE: begin
				if (fx && fy) begin
					r.edge_value = adj_m[x][y];
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.vertex_count = count_m[4:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// result check
	always @(posedge clk) begin
		if (arst_n && done) begin
			amgs_pkg::res_t e;
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", result);
			end else begin
				e = expected_results.pop_front();
				if (result.ok !== e.ok || result.edge_value !== e.edge_value ||
						result.vertex_count !== e.vertex_count) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp ok=%0b val=%0h cnt=%0d, got ok=%0b val=%0h cnt=%0d",
							e.ok, e.edge_value, e.vertex_count,
							result.ok, result.edge_value, result.vertex_count);
				end
			end
		end
	end

	task automatic send_op(amgs_pkg::cmd_t c);
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(apply_operation(c));
		transfers++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2 * NV + 12) @(posedge clk);
	endtask

	task automatic set_kind(logic k);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		kind_m = k;
	endtask

	function automatic amgs_pkg::cmd_t make_op(logic [2:0] m, logic [31:0] v, logic [31:0] f,
			logic [31:0] t, logic [31:0] w);
		amgs_pkg::cmd_t c;
		c.mode = m; c.vertex_id = v; c.from_id = f; c.to_id = t; c.weight = w;
		return c;
	endfunction

	// id pool: a small set of ids so that lookups hit often
	logic [31:0] pool [8] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
		32'h5555_AAAA, 32'hAAAA_5555, 32'd7, 32'd123};

	function automatic logic [31:0] pick_id();
		int unsigned s;
		if ($urandom_range(0, 9) == 0) return $urandom;
		if (count_m != 0 && $urandom_range(0, 2) != 0) begin
			s = $urandom_range(0, count_m - 1);
			return ids_m[(front_m + s) % NV];
		end
		return pool[$urandom_range(0, 7)];
	endfunction

	function automatic logic [31:0] end_id();
		if (count_m == 0) return pick_id();
		return $urandom_range(0, 1) ? ids_m[front_m] : ids_m[rear_m];
	endfunction

	task automatic test_directed();
		set_kind(amgs_pkg::KIND_UNDIRECTED);
		send_op(make_op(amgs_pkg::M_READ_EDGE, 0, 0, 0, 0));
		send_op(make_op(amgs_pkg::M_REM_VERTEX, 0, 0, 0, 0));
		for (int i = 0; i < 8; i++) send_op(make_op(amgs_pkg::M_ADD_VERTEX, pool[i], 0, 0, 0));
		send_op(make_op(amgs_pkg::M_ADD_VERTEX, pool[1], 0, 0, 0));
		send_op(make_op(amgs_pkg::M_ADD_EDGE, 0, pool[0], pool[1], 0));
		send_op(make_op(amgs_pkg::M_ADD_EDGE, 0, pool[2], pool[2], 0));
		send_op(make_op(amgs_pkg::M_ADD_WEIGHT, 0, pool[2], pool[3], 5));
		send_op(make_op(amgs_pkg::M_READ_EDGE, 0, pool[1], pool[0], 0));
		send_op(make_op(amgs_pkg::M_REM_EDGE, 0, pool[3], pool[3], 0));
		send_op(make_op(amgs_pkg::M_REM_EDGE, 0, pool[0], pool[1], 0));
		send_op(make_op(amgs_pkg::M_REM_VERTEX, 0, pool[4], 0, 0));
		send_op(make_op(3'd6, $urandom, $urandom, $urandom, $urandom));
		send_op(make_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		set_kind(amgs_pkg::KIND_DIRECTED);
		send_op(make_op(amgs_pkg::M_ADD_WEIGHT, 0, pool[2], pool[3], 32'h8000_0000));
		send_op(make_op(amgs_pkg::M_ADD_WEIGHT, 0, pool[3], pool[2], 32'h7FFF_FFFF));
		send_op(make_op(amgs_pkg::M_ADD_EDGE, 0, pool[2], pool[3], 0));
		send_op(make_op(amgs_pkg::M_READ_EDGE, 0, pool[2], pool[3], 0));
		send_op(make_op(amgs_pkg::M_REM_EDGE, 0, pool[3], pool[2], 0));
		send_op(make_op(amgs_pkg::M_READ_EDGE, 0, pool[2], pool[3], 0));
		send_op(make_op(amgs_pkg::M_REM_VERTEX, 0, pool[0], 0, 0));
		send_op(make_op(amgs_pkg::M_REM_VERTEX, 0, pool[7], 0, 0));
	endtask

	task automatic test_fill_and_wrap();
		for (int i = 0; i < 20; i++)
			send_op(make_op(amgs_pkg::M_ADD_VERTEX, $urandom, 0, 0, 0));
		for (int i = 0; i < 20; i++) begin
			send_op(make_op(amgs_pkg::M_REM_VERTEX, end_id(), 0, 0, 0));
			send_op(make_op(amgs_pkg::M_ADD_VERTEX, $urandom, 0, 0, 0));
		end
	endtask

	task automatic test_random(int n);
		amgs_pkg::cmd_t c;
		int m;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(0, 9);
			if (m > 7) m = int'(amgs_pkg::M_READ_EDGE);
			c.mode = 3'(m);
			if (c.mode > 3'd5 && $urandom_range(0, 3) != 0) c.mode = amgs_pkg::M_ADD_VERTEX;
			c.vertex_id = (c.mode == amgs_pkg::M_REM_VERTEX && $urandom_range(0, 3) != 0)
				? end_id() : pick_id();
			c.from_id = pick_id();
			c.to_id = pick_id();
			c.weight = $urandom;
			if (count_m > 12 && c.mode == amgs_pkg::M_ADD_VERTEX && $urandom_range(0, 1))
				c.mode = amgs_pkg::M_REM_VERTEX;
			send_op(c);
		end
	endtask

	initial begin
		kind_m = amgs_pkg::KIND_UNDIRECTED;
		front_m = 0;
		rear_m = NV - 1;
		count_m = 0;
		for (int i = 0; i < NV; i++) begin
			ids_m[i] = '0;
			for (int j = 0; j < NV; j++) adj_m[i][j] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_wrap();
		set_kind(amgs_pkg::KIND_UNDIRECTED);
		test_random(150);
		set_kind(amgs_pkg::KIND_DIRECTED);
		test_random(150);
		set_kind(amgs_pkg::KIND_UNDIRECTED);
		calm = 1'b1;
		test_random(60);
		drain();
		$display("ran %0d operations in both graph kinds, %0d results checked", transfers,
			results_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
rtl/amgs_pkg.sv
rtl/amgs_datapath.sv
rtl/amgs_ctrl.sv
rtl/adjacency_matrix_graph_store_unit.sv
test/adjacency_matrix_graph_store_unit_test.sv
